### hw/rtl/mmp_pkg.sv
// Shared types and constants for the MIDI message parser.
`default_nettype none

package mmp_pkg;

    // Parser phase, one code per expected byte of a message
    typedef enum logic [3:0] {
        PH_STATUS   = 4'd0,
        PH_ON_KEY   = 4'd1,
        PH_OFF_KEY  = 4'd2,
        PH_CTL_NUM  = 4'd3,
        PH_ON_VEL   = 4'd4,
        PH_OFF_VEL  = 4'd5,
        PH_PATCH    = 4'd6,
        PH_VOLUME   = 4'd7,
        PH_MODAMT   = 4'd8,
        PH_TAU      = 4'd9,
        PH_BEND_LO  = 4'd10,
        PH_BEND_HI  = 4'd11,
        PH_MODULATE = 4'd12,
        PH_SKIP     = 4'd13
    } mmp_phase_t;

    // Event kinds reported on the result stream
    typedef enum logic [2:0] {
        EV_NOTE_ON  = 3'd0,
        EV_NOTE_OFF = 3'd1,
        EV_PATCH    = 3'd2,
        EV_VOLUME   = 3'd3,
        EV_TAU      = 3'd4,
        EV_MODAMT   = 3'd5,
        EV_MODULATE = 3'd6,
        EV_BEND     = 3'd7
    } mmp_event_kind_t;

    // Register index (byte address / 4)
    typedef enum logic [2:0] {
        REG_CODE_NOTE_ON   = 3'd0,
        REG_CODE_NOTE_OFF  = 3'd1,
        REG_CODE_CONTROL   = 3'd2,
        REG_CODE_BEND      = 3'd3,
        REG_CTL_PATCH      = 3'd4,
        REG_CTL_TAU        = 3'd5,
        REG_CTL_MOD_AMOUNT = 3'd6,
        REG_CTL_VOLUME     = 3'd7
    } mmp_reg_idx_t;

    localparam int unsigned PADDR_W = 5;
    localparam int unsigned PDATA_W = 32;

    localparam logic [7:0] CODE_NOTE_ON_RST   = 8'd144;
    localparam logic [7:0] CODE_NOTE_OFF_RST  = 8'd128;
    localparam logic [7:0] CODE_CONTROL_RST   = 8'd176;
    localparam logic [7:0] CODE_BEND_RST      = 8'd224;
    localparam logic [7:0] CTL_PATCH_RST      = 8'd74;
    localparam logic [7:0] CTL_TAU_RST        = 8'd75;
    localparam logic [7:0] CTL_MOD_AMOUNT_RST = 8'd76;
    localparam logic [7:0] CTL_VOLUME_RST     = 8'd7;
    localparam logic [7:0] PATCH_RST          = 8'd60;
    localparam logic [7:0] TAU_RST            = 8'd0;

    typedef struct packed {
        logic [7:0] code_note_on;
        logic [7:0] code_note_off;
        logic [7:0] code_control;
        logic [7:0] code_bend;
        logic [7:0] ctl_patch;
        logic [7:0] ctl_tau;
        logic [7:0] ctl_mod_amount;
        logic [7:0] ctl_volume;
    } mmp_cfg_t;

    typedef struct packed {
        logic            emit;
        mmp_event_kind_t kind;
        logic [7:0]      key;
        logic [7:0]      amount;
        logic [14:0]     bend;
        logic [7:0]      patch_now;
        logic [7:0]      tau_now;
    } mmp_event_t;

endpackage

`default_nettype wire

### hw/rtl/mmp_cfg_regs.sv
// APB register file holding the status codes and controller numbers.
`default_nettype none

module mmp_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mmp_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [mmp_pkg::PDATA_W-1:0]   pwdata,
    output logic      [mmp_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    output mmp_pkg::mmp_cfg_t                  cfg
);
    import mmp_pkg::*;

    mmp_cfg_t     cfg_reg;
    mmp_reg_idx_t idx;
    logic         wr_en;
    logic [7:0]   rd_byte;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = mmp_reg_idx_t'(paddr[PADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code_note_on   <= CODE_NOTE_ON_RST;
            cfg_reg.code_note_off  <= CODE_NOTE_OFF_RST;
            cfg_reg.code_control   <= CODE_CONTROL_RST;
            cfg_reg.code_bend      <= CODE_BEND_RST;
            cfg_reg.ctl_patch      <= CTL_PATCH_RST;
            cfg_reg.ctl_tau        <= CTL_TAU_RST;
            cfg_reg.ctl_mod_amount <= CTL_MOD_AMOUNT_RST;
            cfg_reg.ctl_volume     <= CTL_VOLUME_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_CODE_NOTE_ON:   cfg_reg.code_note_on   <= pwdata[7:0];
                REG_CODE_NOTE_OFF:  cfg_reg.code_note_off  <= pwdata[7:0];
                REG_CODE_CONTROL:   cfg_reg.code_control   <= pwdata[7:0];
                REG_CODE_BEND:      cfg_reg.code_bend      <= pwdata[7:0];
                REG_CTL_PATCH:      cfg_reg.ctl_patch      <= pwdata[7:0];
                REG_CTL_TAU:        cfg_reg.ctl_tau        <= pwdata[7:0];
                REG_CTL_MOD_AMOUNT: cfg_reg.ctl_mod_amount <= pwdata[7:0];
                REG_CTL_VOLUME:     cfg_reg.ctl_volume     <= pwdata[7:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_CODE_NOTE_ON:   rd_byte = cfg_reg.code_note_on;
            REG_CODE_NOTE_OFF:  rd_byte = cfg_reg.code_note_off;
            REG_CODE_CONTROL:   rd_byte = cfg_reg.code_control;
            REG_CODE_BEND:      rd_byte = cfg_reg.code_bend;
            REG_CTL_PATCH:      rd_byte = cfg_reg.ctl_patch;
            REG_CTL_TAU:        rd_byte = cfg_reg.ctl_tau;
            REG_CTL_MOD_AMOUNT: rd_byte = cfg_reg.ctl_mod_amount;
            REG_CTL_VOLUME:     rd_byte = cfg_reg.ctl_volume;
            default:            rd_byte = '0;
        endcase
    end

    assign prdata = {{(PDATA_W-8){1'b0}}, rd_byte};

endmodule

`default_nettype wire

### hw/rtl/mmp_parser.sv
// Message state machine: phase, held bytes and stored patch/tau.
`default_nettype none

module mmp_parser #(
    parameter int unsigned CTL_MODULATE = 77
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic [7:0]           rx_byte,
    input  wire mmp_pkg::mmp_cfg_t    cfg,
    output mmp_pkg::mmp_event_t       ev
);
    import mmp_pkg::*;

    mmp_phase_t phase_reg, phase_next;
    logic [7:0] held_key_reg, held_key_next;
    logic [7:0] bend_low_reg, bend_low_next;
    logic [7:0] patch_reg, patch_next;
    logic [7:0] tau_reg, tau_next;
    logic [7:0] ctl_modulate;

    assign ctl_modulate = CTL_MODULATE[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_STATUS;
            held_key_reg <= '0;
            bend_low_reg <= '0;
            patch_reg    <= PATCH_RST;
            tau_reg      <= TAU_RST;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            held_key_reg <= held_key_next;
            bend_low_reg <= bend_low_next;
            patch_reg    <= patch_next;
            tau_reg      <= tau_next;
        end
    end

    // Next phase
    always_comb
    begin
        unique case (phase_reg) inside
            PH_ON_KEY:  phase_next = PH_ON_VEL;
            PH_OFF_KEY: phase_next = PH_OFF_VEL;
            PH_CTL_NUM:
            begin
                // earlier controller numbers win on a tie
                if (rx_byte == cfg.ctl_patch)           phase_next = PH_PATCH;
                else if (rx_byte == cfg.ctl_tau)        phase_next = PH_TAU;
                else if (rx_byte == cfg.ctl_mod_amount) phase_next = PH_MODAMT;
                else if (rx_byte == cfg.ctl_volume)     phase_next = PH_VOLUME;
                else if (rx_byte == ctl_modulate)       phase_next = PH_MODULATE;
                else                                    phase_next = PH_SKIP;
            end
            PH_BEND_LO: phase_next = PH_BEND_HI;
            PH_ON_VEL, PH_OFF_VEL, PH_SKIP, PH_PATCH, PH_VOLUME, PH_TAU,
            PH_MODAMT, PH_MODULATE, PH_BEND_HI:
                phase_next = PH_STATUS;
            default:
            begin
                // status byte; unused codes behave the same
                if (rx_byte == cfg.code_note_on)       phase_next = PH_ON_KEY;
                else if (rx_byte == cfg.code_note_off) phase_next = PH_OFF_KEY;
                else if (rx_byte == cfg.code_control)  phase_next = PH_CTL_NUM;
                else if (rx_byte == cfg.code_bend)     phase_next = PH_BEND_LO;
                else                                   phase_next = PH_SKIP;
            end
        endcase
    end

    // Event and data updates
    always_comb
    begin
        held_key_next = held_key_reg;
        bend_low_next = bend_low_reg;
        patch_next    = patch_reg;
        tau_next      = tau_reg;
        ev.emit       = 1'b0;
        ev.kind       = EV_NOTE_ON;
        ev.key        = '0;
        ev.amount     = '0;
        ev.bend       = '0;
        unique case (phase_reg)
            PH_ON_KEY:  held_key_next = rx_byte;
            PH_OFF_KEY:
            begin
                ev.emit = 1'b1;
                ev.kind = EV_NOTE_OFF;
                ev.key  = rx_byte;
            end
            PH_ON_VEL:
            begin
                ev.emit   = 1'b1;
                ev.kind   = EV_NOTE_ON;
                ev.key    = held_key_reg;
                ev.amount = rx_byte;
            end
            PH_PATCH:
            begin
                patch_next = rx_byte;
                ev.emit    = 1'b1;
                ev.kind    = EV_PATCH;
                ev.amount  = rx_byte;
            end
            PH_VOLUME:
            begin
                ev.emit   = 1'b1;
                ev.kind   = EV_VOLUME;
                ev.amount = rx_byte;
            end
            PH_TAU:
            begin
                tau_next  = rx_byte;
                ev.emit   = 1'b1;
                ev.kind   = EV_TAU;
                ev.amount = rx_byte;
            end
            PH_MODAMT:
            begin
                ev.emit   = 1'b1;
                ev.kind   = EV_MODAMT;
                ev.amount = rx_byte;
            end
            PH_MODULATE:
            begin
                ev.emit   = 1'b1;
                ev.kind   = EV_MODULATE;
                ev.amount = rx_byte;
            end
            PH_BEND_LO: bend_low_next = rx_byte;
            PH_BEND_HI:
            begin
                // bit 0 of the high byte overlaps bit 7 of the low byte
                ev.emit = 1'b1;
                ev.kind = EV_BEND;
                ev.bend = {rx_byte, 7'b0} | {7'b0, bend_low_reg};
            end
            default: ;
        endcase
        ev.patch_now = patch_next;
        ev.tau_now   = tau_next;
    end

endmodule

`default_nettype wire

### hw/rtl/midi_message_parser_top.sv
// Top level of the MIDI message parser: stream ports, pipeline registers, APB port.
// An accepted byte waits in the input register; its event is then registered for m_tvalid.
// Throughput: one byte per cycle unless the output stalls; one phase update per byte.
// The input register and the result register each hold one item; both advance together
// whenever the result register is empty or being taken, so a stalled output costs no bubble.
// Reset (rst_n, async, low): phase waits for a status byte, patch 60, tau 0, codes default.
`default_nettype none

module midi_message_parser_top #(
    parameter int unsigned CTL_MODULATE = 77
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // input stream
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // [7:0] key, [15:8] amount, [30:16] bend, [38:31] patch_now, [46:39] tau_now, pad
    output logic [47:0]                      m_tdata,
    output logic [2:0]                       m_tuser,   // [2:0] event_kind
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mmp_pkg::PADDR_W-1:0] paddr,
    input  wire logic [mmp_pkg::PDATA_W-1:0] pwdata,
    output logic      [mmp_pkg::PDATA_W-1:0] prdata,
    output logic                             pready
);
    import mmp_pkg::*;

    mmp_cfg_t   cfg;
    mmp_event_t ev;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // result register
    logic       out_valid_reg;
    mmp_event_t out_ev_reg;

    logic out_free;   // result register can take a new value this cycle
    logic proc;       // the held byte is parsed this cycle

    assign out_free = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    mmp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mmp_parser #(
        .CTL_MODULATE (CTL_MODULATE)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (proc),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .ev      (ev)
    );

    // Input stage: refills whenever the held byte moves on (or none is held).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // Result stage: bytes that produce no event leave it empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= proc && ev.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && ev.emit)
        begin
            out_ev_reg <= ev;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ev_reg.kind;
    assign m_tdata  = {1'b0, out_ev_reg.tau_now, out_ev_reg.patch_now, out_ev_reg.bend,
                       out_ev_reg.amount, out_ev_reg.key};

endmodule

`default_nettype wire
